FILE: rtl/core/keyed_record_table_macros.svh
// assertion shorthands for the record table checks
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk and quiet while rst is high
`define KRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed_record_table check failed");

// next-cycle implication, sampled on clk and quiet while rst is high
`define KRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed_record_table check failed");

`endif

FILE: rtl/core/krt_pkg.sv
package krt_pkg;

  // operation codes carried in mode
  typedef enum logic [2:0] {
    MODE_INSERT    = 3'd0,
    MODE_LOOKUP    = 3'd1,
    MODE_REMOVE    = 3'd2,
    MODE_MAX       = 3'd3,
    MODE_MIN       = 3'd4,
    MODE_LIST_FLAG = 3'd5,
    MODE_LIST_ALL  = 3'd6,
    MODE_CLEAR     = 3'd7
  } mode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic [3:0] SCORE_MAX = 4'd10;

  // one stored record
  typedef struct packed {
    logic [31:0] key;
    logic [3:0]  score;
    logic        flag;
  } rec_t;

  // one result beat
  typedef struct packed {
    status_t status;
    rec_t    rec;
    logic    last;
  } res_t;

  function automatic res_t make_res(status_t st, rec_t rec, logic last);
    res_t r;
    r.status = st;
    r.rec    = rec;
    r.last   = last;
    return r;
  endfunction

endpackage

FILE: rtl/core/krt_req_if.sv
interface krt_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] key_id;
  logic [3:0]         score_in;
  logic               flag_in;

  modport source (output valid, mode, key_id, score_in, flag_in, input ready);
  modport sink (input valid, mode, key_id, score_in, flag_in, output ready);
endinterface

FILE: rtl/core/krt_rsp_if.sv
interface krt_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] rec_id;
  logic [3:0]         rec_score;
  logic               rec_flag;
  logic               last;

  modport source (output valid, status, rec_id, rec_score, rec_flag, last, input ready);
  modport sink (input valid, status, rec_id, rec_score, rec_flag, last, output ready);
endinterface

FILE: rtl/core/krt_mem.sv
module krt_mem #(
  parameter int ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
  input  krt_pkg::rec_t                        wr_data,
  input  logic                                 rd_en,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
  output krt_pkg::rec_t                        rd_data
);

  krt_pkg::rec_t mem [ENTRIES];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/krt_ctrl.sv
module krt_ctrl #(
  parameter int ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  krt_req_if.sink                              req,
  krt_rsp_if.source                            rsp,
  output logic                                 mem_wr_en,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] mem_wr_addr,
  output krt_pkg::rec_t                        mem_wr_data,
  output logic                                 mem_rd_en,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] mem_rd_addr,
  input  krt_pkg::rec_t                        mem_rd_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DONE,
    S_SEND,
    S_SHIFT
  } state_t;

  state_t               state;
  krt_pkg::mode_t       mode_r;
  logic [31:0]          key_r;
  logic [3:0]           score_r;
  logic                 flag_r;
  logic [CW-1:0]        count;
  logic [CW-1:0]        rd_idx;
  logic                 dv;
  logic [AW-1:0]        dv_idx;
  logic [AW-1:0]        hit_idx;
  krt_pkg::rec_t        best;
  krt_pkg::rec_t        held;
  logic                 have_held;
  krt_pkg::res_t        pend;
  logic                 out_valid;
  krt_pkg::res_t        out_res;

  logic                 out_free;
  logic                 last_data;
  logic                 key_hit;
  logic                 is_list;
  logic                 is_keyed;
  logic                 list_match;
  logic                 stall;
  logic                 stop;
  logic                 issue;
  logic                 load_out;
  logic                 better;
  krt_pkg::rec_t        best_next;
  krt_pkg::rec_t        ins_rec;
  logic                 shift_wr;
  logic                 ins_wr;
  logic [CW-1:0]        hit_next;

  // scan bookkeeping
  always_comb begin
    out_free   = !out_valid || rsp.ready;
    last_data  = dv && ((CW'(dv_idx) + CW'(1)) == count);
    key_hit    = dv && (mem_rd_data.key == key_r);
    is_list    = (mode_r == krt_pkg::MODE_LIST_FLAG) || (mode_r == krt_pkg::MODE_LIST_ALL);
    is_keyed   = (mode_r == krt_pkg::MODE_INSERT) || (mode_r == krt_pkg::MODE_LOOKUP) ||
                 (mode_r == krt_pkg::MODE_REMOVE);
    list_match = dv && ((mode_r == krt_pkg::MODE_LIST_ALL) || mem_rd_data.flag);
    stall      = (state == S_SCAN) && is_list && list_match && have_held && !out_free;
    stop       = (state == S_SCAN) && is_keyed && key_hit;
    issue      = (((state == S_SCAN) && !stall && !stop) || (state == S_SHIFT)) &&
                 (rd_idx < count);
    load_out   = ((state == S_SCAN) && is_list && list_match && !stall && have_held) ||
                 ((state == S_SEND) && out_free);
    hit_next   = CW'(hit_idx) + CW'(1);
  end

  // running extreme, earliest entry wins ties
  always_comb begin
    if (mode_r == krt_pkg::MODE_MAX) begin
      better = mem_rd_data.score > best.score;
    end else begin
      better = mem_rd_data.score < best.score;
    end
    if ((dv_idx == '0) || better) begin
      best_next = mem_rd_data;
    end else begin
      best_next = best;
    end
  end

  // memory port drive: reads during scan and shift, writes on shift and append
  always_comb begin
    ins_rec.key   = key_r;
    ins_rec.score = score_r;
    ins_rec.flag  = flag_r;
    shift_wr      = (state == S_SHIFT) && dv;
    ins_wr        = (state == S_DONE) && (count != FULL_COUNT);
    mem_rd_en     = issue;
    mem_rd_addr   = rd_idx[AW-1:0];
    mem_wr_en     = shift_wr || ins_wr;
    if (shift_wr) begin
      mem_wr_addr = dv_idx - AW'(1);
      mem_wr_data = mem_rd_data;
    end else begin
      mem_wr_addr = count[AW-1:0];
      mem_wr_data = ins_rec;
    end
  end

  // handshake and payload outputs
  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_res.status;
  assign rsp.rec_id    = out_res.rec.key;
  assign rsp.rec_score = out_res.rec.score;
  assign rsp.rec_flag  = out_res.rec.flag;
  assign rsp.last      = out_res.last;

  // sequencer, read pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      dv        <= 1'b0;
      have_held <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output register: load a new beat or retire the taken one
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (issue) begin
        dv     <= 1'b1;
        dv_idx <= rd_idx[AW-1:0];
        rd_idx <= rd_idx + CW'(1);
      end else if (!stall) begin
        dv <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode_r    <= krt_pkg::mode_t'(req.mode);
            key_r     <= req.key_id;
            score_r   <= (req.score_in > krt_pkg::SCORE_MAX) ? krt_pkg::SCORE_MAX
                                                             : req.score_in;
            flag_r    <= req.flag_in;
            have_held <= 1'b0;
            rd_idx    <= '0;
            if (krt_pkg::mode_t'(req.mode) == krt_pkg::MODE_CLEAR) begin
              count <= '0;
              pend  <= krt_pkg::make_res(krt_pkg::ST_OK, '0, 1'b1);
              state <= S_SEND;
            end else if (krt_pkg::mode_t'(req.mode) == krt_pkg::MODE_INSERT) begin
              state <= (count == '0) ? S_DONE : S_SCAN;
            end else if (count == '0) begin
              pend  <= krt_pkg::make_res(krt_pkg::ST_EMPTY, '0, 1'b1);
              state <= S_SEND;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          unique case (mode_r)
            krt_pkg::MODE_INSERT: begin
              if (key_hit) begin
                pend  <= krt_pkg::make_res(krt_pkg::ST_DUP, '0, 1'b1);
                state <= S_SEND;
              end else if (last_data) begin
                state <= S_DONE;
              end
            end
            krt_pkg::MODE_LOOKUP, krt_pkg::MODE_REMOVE: begin
              if (key_hit) begin
                pend    <= krt_pkg::make_res(krt_pkg::ST_OK, mem_rd_data, 1'b1);
                hit_idx <= dv_idx;
                state   <= S_SEND;
              end else if (last_data) begin
                pend  <= krt_pkg::make_res(krt_pkg::ST_NOTFOUND, '0, 1'b1);
                state <= S_SEND;
              end
            end
            krt_pkg::MODE_MAX, krt_pkg::MODE_MIN: begin
              if (dv) begin
                best <= best_next;
              end
              if (last_data) begin
                pend  <= krt_pkg::make_res(krt_pkg::ST_OK, best_next, 1'b1);
                state <= S_SEND;
              end
            end
            krt_pkg::MODE_LIST_FLAG, krt_pkg::MODE_LIST_ALL: begin
              // hold one match back so the final beat can carry last
              if (list_match && !stall) begin
                if (have_held) begin
                  out_res <= krt_pkg::make_res(krt_pkg::ST_OK, held, 1'b0);
                end
                held      <= mem_rd_data;
                have_held <= 1'b1;
              end
              if (last_data && !stall) begin
                if (list_match) begin
                  pend <= krt_pkg::make_res(krt_pkg::ST_OK, mem_rd_data, 1'b1);
                end else if (have_held) begin
                  pend <= krt_pkg::make_res(krt_pkg::ST_OK, held, 1'b1);
                end else begin
                  pend <= krt_pkg::make_res(krt_pkg::ST_NOTFOUND, '0, 1'b1);
                end
                state <= S_SEND;
              end
            end
            krt_pkg::MODE_CLEAR: begin
              state <= S_IDLE;
            end
          endcase
        end

        S_DONE: begin
          // append after a clean duplicate scan or on an empty table, or report full
          if (count == FULL_COUNT) begin
            pend <= krt_pkg::make_res(krt_pkg::ST_FULL, '0, 1'b1);
          end else begin
            pend  <= krt_pkg::make_res(krt_pkg::ST_OK, ins_rec, 1'b1);
            count <= count + CW'(1);
          end
          state <= S_SEND;
        end

        S_SEND: begin
          if (out_free) begin
            out_res <= pend;
            if ((mode_r == krt_pkg::MODE_REMOVE) && (pend.status == krt_pkg::ST_OK)) begin
              if (hit_next == count) begin
                count <= count - CW'(1);
                state <= S_IDLE;
              end else begin
                rd_idx <= hit_next;
                state  <= S_SHIFT;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_SHIFT: begin
          // move later entries down one slot, one per cycle
          if (last_data) begin
            count <= count - CW'(1);
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/keyed_record_table.sv
// Ordered key table of up to ENTRIES records (key, score 0..10, flag) kept in
// insertion order in one single-port-read, single-port-write memory. One
// request beat on req carries an operation; the answer comes back on rsp as
// one beat, or for the list modes one beat per matching record with last on
// the final one. Requests are taken one at a time: req.ready is high only
// between operations. The memory is walked one entry per cycle while no list
// result beat is held up on rsp.ready, and a keyed search stops at the hit; a
// remove then shifts the later entries down one slot each. Clear, and every
// operation but insert on an empty table, answer without walking the memory,
// an insert on an empty table appends without a scan, and every result beat
// also waits on rsp.ready.
// Stored records are not cleared at reset; only the entry count is.
module keyed_record_table #(
  parameter int ENTRIES = 16
) (
  input logic       clk,
  input logic       rst,
  krt_req_if.sink   req,
  krt_rsp_if.source rsp
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  krt_pkg::rec_t mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  krt_pkg::rec_t mem_rd_data;

  // record store
  krt_mem #(
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // operation sequencer
  krt_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule

FILE: rtl/core/krt_checker.sv
`include "keyed_record_table_macros.svh"

module krt_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic [31:0] rec_id,
  input logic [3:0]  rec_score,
  input logic        rec_flag,
  input logic        last
);

  logic [40:0] beat;
  logic        rec_zero;

  // result payload as one vector, and a zero record
  assign beat     = {status, rec_id, rec_score, rec_flag, last};
  assign rec_zero = (rec_id == 32'd0) && (rec_score == 4'd0) && !rec_flag;

  // a stalled result beat stays up
  `KRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

  // and keeps its payload
  `KRT_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(beat))

  // error results are single, final and carry a zero record
  `KRT_ASSERT_NOW(a_err_beat, rsp_valid && (status != krt_pkg::ST_OK), last && rec_zero)

  // stored scores never exceed the saturation limit
  `KRT_ASSERT_NOW(a_score_range, rsp_valid, rec_score <= krt_pkg::SCORE_MAX)

endmodule

bind keyed_record_table krt_checker u_krt_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .rec_id    (rsp.rec_id),
  .rec_score (rsp.rec_score),
  .rec_flag  (rsp.rec_flag),
  .last      (rsp.last)
);
